// ----- rtl/aabb_frustum_visibility_test_defines.svh -----
// Assertion helpers for the frustum visibility test block.
`ifndef AABB_FRUSTUM_VISIBILITY_TEST_DEFINES_SVH
`define AABB_FRUSTUM_VISIBILITY_TEST_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AFVT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AFVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/afvt_pkg.sv -----
package afvt_pkg;

    localparam int PLANES     = 6;
    localparam int COORD_BITS = 32;

    localparam int COEF_W   = 32;
    localparam int VAL_BITS = (COORD_BITS >= COEF_W) ? COEF_W : COORD_BITS;
    localparam int VAL_SH   = COEF_W - VAL_BITS;

    localparam int PLANE_AW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int CNT_W    = $clog2(PLANES + 1);
    localparam int PLANE_W  = 4 * COEF_W;          // a, b, c, d from the low bits up

    localparam int PROD_W = 2 * COEF_W;            // exact Q32.32 product
    localparam int SUM_W  = PROD_W + 1;            // pair sum
    localparam int TOT_W  = PROD_W + 2;            // sum of four terms
    localparam int D_SH   = 16;                    // Q16.16 -> Q32.32 alignment

    localparam int IDX_W       = 3;
    localparam int IN_TDATA_W  = 328;              // 3 + 10*32 = 323, padded to bytes
    localparam int OUT_TDATA_W = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    // Take the low VAL_BITS bits and sign-extend them.
    function automatic logic signed [COEF_W-1:0] sext_val(logic [COEF_W-1:0] v);
        logic signed [COEF_W-1:0] t;
        t = $signed(v << VAL_SH);
        return t >>> VAL_SH;
    endfunction

endpackage

// ----- rtl/afvt_ram.sv -----
module afvt_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [W-1:0]                                  i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [W-1:0]                                  o_rd_data
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/aabb_frustum_visibility_test.sv -----
// Axis-aligned box versus frustum test. The block stores PLANES planes
// (a, b, c, d in Q16.16) in a small plane memory; a load item (tuser = 0)
// writes one plane and is answered by one acknowledge item (kind 0,
// visible 0); a load with an index at or above PLANES writes nothing but is
// still acknowledged. A test item (tuser = 1) brings a box's min and max
// corners; for every stored plane the positive vertex is picked per axis
// (min where the coefficient is negative, else max), a*x+b*y+c*z+(d<<16)
// is formed exactly, and a negative sum clears visible. Planes never loaded
// since reset read as zero and reject nothing. Items are handled one at a
// time: the plane memory's single read port feeds one dot-product unit one
// plane per cycle, through its three pipeline stages. A finished result
// waits in an output register, so a new item is taken while the previous
// result is still unread.
`include "aabb_frustum_visibility_test_defines.svh"

module aabb_frustum_visibility_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] plane_index, [34:3] coef_a, [66:35] coef_b, [98:67] coef_c,
    // [130:99] coef_d, [162:131] box_min_x, [194:163] box_min_y,
    // [226:195] box_min_z, [258:227] box_max_x, [290:259] box_max_y,
    // [322:291] box_max_z, [327:323] zero
    input  logic [afvt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] func
    input  logic                              i_s_tuser,
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] visible, [7:1] zero
    output logic [afvt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // [0] kind
    output logic                              o_m_tuser
);
    import afvt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // ---------------------------------------------------------------
    // Input unpacking
    // ---------------------------------------------------------------
    logic                     in_acc;
    logic [IDX_W-1:0]         in_idx;
    logic [PLANE_W-1:0]       in_plane;
    logic                     in_idx_ok;

    assign in_acc    = i_s_tvalid && o_s_tready;
    assign in_idx    = i_s_tdata[2:0];
    assign in_plane  = i_s_tdata[130:3];          // a, b, c, d low to high
    assign in_idx_ok = (int'(in_idx) < PLANES);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_rd_cnt;               // planes issued so far
    logic [PLANES-1:0]  r_plane_vld;            // plane written since reset
    logic               r_kind;
    logic               r_vis;

    // box corners, held for the whole test
    logic signed [COEF_W-1:0] r_mn [3];
    logic signed [COEF_W-1:0] r_mx [3];

    // pipeline: s1 = memory data, s2 = products, s3 = pair sums
    logic r_s1_vld, r_s2_vld, r_s3_vld;
    logic r_s1_last, r_s2_last, r_s3_last;
    logic r_s1_hit;                              // entry valid at read time

    logic                     rd_issue;
    logic [PLANE_AW-1:0]      rd_addr;
    logic [PLANE_W-1:0]       rd_data;
    logic                     out_free;

    assign rd_issue = (r_state == ST_RUN) && (int'(r_rd_cnt) < PLANES);
    assign rd_addr  = r_rd_cnt[PLANE_AW-1:0];
    assign out_free = !o_m_tvalid || i_m_tready;

    assign o_s_tready = (r_state == ST_IDLE);

    // plane memory: writes only from load items, reads only while testing
    afvt_ram #(
        .W     (PLANE_W),
        .DEPTH (PLANES)
    ) u_plane_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (i_s_tuser == FUNC_LOAD) && in_idx_ok),
        .i_wr_addr (in_idx[PLANE_AW-1:0]),
        .i_wr_data (in_plane),
        .i_rd_en   (rd_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Stage 1 -> 2: positive vertex and products
    // ---------------------------------------------------------------
    logic [PLANE_W-1:0]       pl;
    logic signed [COEF_W-1:0] cf [4];
    logic signed [COEF_W-1:0] vx [3];

    always_comb begin
        pl = r_s1_hit ? rd_data : '0;           // unwritten plane reads as zero
        for (int k = 0; k < 4; k++) begin
            cf[k] = sext_val(pl[k*COEF_W +: COEF_W]);
        end
        for (int k = 0; k < 3; k++) begin
            vx[k] = cf[k][COEF_W-1] ? r_mn[k] : r_mx[k];
        end
    end

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] r_dterm;
    logic signed [SUM_W-1:0]  r_sum01, r_sum23;
    logic signed [TOT_W-1:0]  total;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= PROD_W'(cf[k]) * PROD_W'(vx[k]);
        end
        r_dterm <= PROD_W'(cf[3]) <<< D_SH;
        r_sum01 <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]);
        r_sum23 <= SUM_W'(r_prod[2]) + SUM_W'(r_dterm);
    end

    // final add; only the sign matters
    assign total = TOT_W'(r_sum01) + TOT_W'(r_sum23);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_tuser == FUNC_TEST) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (r_s3_vld && r_s3_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_cnt    <= '0;
            r_plane_vld <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_kind      <= KIND_ACK;
            r_vis       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= rd_issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;

            if (in_acc) begin
                r_rd_cnt <= '0;
                if (i_s_tuser == FUNC_TEST) begin
                    r_kind <= KIND_TEST;
                    r_vis  <= 1'b1;
                end else begin
                    r_kind <= KIND_ACK;
                    r_vis  <= 1'b0;
                    if (in_idx_ok) begin
                        r_plane_vld[in_idx[PLANE_AW-1:0]] <= 1'b1;
                    end
                end
            end else begin
                if (rd_issue) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
                if (r_s3_vld && total[TOT_W-1]) begin
                    r_vis <= 1'b0;                  // this plane rejects the box
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_last <= (int'(r_rd_cnt) == PLANES - 1);
        r_s1_hit  <= r_plane_vld[rd_addr];
        r_s2_last <= r_s1_last;
        r_s3_last <= r_s2_last;
        if (in_acc) begin
            r_mn[0] <= sext_val(i_s_tdata[162:131]);
            r_mn[1] <= sext_val(i_s_tdata[194:163]);
            r_mn[2] <= sext_val(i_s_tdata[226:195]);
            r_mx[0] <= sext_val(i_s_tdata[258:227]);
            r_mx[1] <= sext_val(i_s_tdata[290:259]);
            r_mx[2] <= sext_val(i_s_tdata[322:291]);
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic r_o_valid, r_o_kind, r_o_vis;
    logic out_load;

    assign out_load = (r_state == ST_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind <= r_kind;
            r_o_vis  <= r_vis;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_o_vis};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `AFVT_ASSERT_SAME(a_pipe_only_in_run, (r_s1_vld || r_s2_vld || r_s3_vld),
        (r_state == ST_RUN), "plane pipeline active outside a box test")
    `AFVT_ASSERT_SAME(a_cnt_bound, 1'b1, (int'(r_rd_cnt) <= PLANES),
        "plane read counter ran past the plane count")
    `AFVT_ASSERT_NEXT(a_test_start, (in_acc && (i_s_tuser == FUNC_TEST)),
        (r_vis && (r_rd_cnt == '0) && (r_state == ST_RUN)), "box test did not start clean")
    `AFVT_ASSERT_SAME(a_ack_not_visible, (out_load && (r_kind == KIND_ACK)), !r_vis,
        "load acknowledge with visible set")

endmodule
